>>> hw/rtl/lcs_pkg.sv
package lcs_pkg;

  localparam int CFG_W = 9;

  localparam logic REG_INPUT_LEN  = 1'b0;
  localparam logic REG_HIDDEN_LEN = 1'b1;

  localparam logic [2:0] CMD_IN_WEIGHT  = 3'd0;
  localparam logic [2:0] CMD_REC_WEIGHT = 3'd1;
  localparam logic [2:0] CMD_BIAS       = 3'd2;
  localparam logic [2:0] CMD_H_INIT     = 3'd3;
  localparam logic [2:0] CMD_C_INIT     = 3'd4;
  localparam logic [2:0] CMD_INPUT      = 3'd5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [8:0]         row;
    logic [7:0]         col;
    logic signed [15:0] value;
    logic               last;
  } req_t;

  typedef struct packed {
    logic [5:0]         unit;
    logic signed [15:0] hidden_out;
    logic signed [15:0] cell_out;
    logic               end_of_step;
  } rsp_t;

  // broadcast to every cell of the state ring
  typedef struct packed {
    logic               shift;
    logic               wr_h;
    logic               wr_c;
    logic signed [15:0] wdata;
    logic signed [15:0] wrap_h;
    logic signed [15:0] wrap_c;
  } ring_ctl_t;

  typedef struct packed {
    logic sel;
    logic tail;
    logic act;
  } cell_pos_t;

  typedef logic [255:0][15:0] tab_t;

  // sigmoid or tanh of k/16, k = signed table index, Q4.12
  function automatic tab_t make_tab(input logic use_tanh);
    logic [63:0] e [0:256];
    logic [63:0] den;
    logic [63:0] rem;
    logic [15:0] quo;
    tab_t        t;
    int          k;
    int          a;
    int          n;
    e[0] = 64'd1 << 32;
    for (int m = 1; m <= 256; m++) begin
      e[m] = (e[m - 1] * 64'd4034748382 + (64'd1 << 31)) >> 32;
    end
    for (int m = 0; m < 256; m++) begin
      k = (m < 128) ? m : m - 256;
      a = (k < 0) ? -k : k;
      n = use_tanh ? 2 * a : a;
      den = (64'd1 << 32) + e[n];
      if (use_tanh) begin
        rem = (((64'd1 << 32) - e[n]) << 12) + (den >> 1);
      end else begin
        rem = (64'd1 << 44) + (den >> 1);
      end
      quo = '0;
      // long division, quotient stays below 2^14
      for (int b = 13; b >= 0; b--) begin
        if (rem >= (den << b)) begin
          rem = rem - (den << b);
          quo[b] = 1'b1;
        end
      end
      if (k < 0) begin
        t[m] = use_tanh ? (16'd0 - quo) : (16'd4096 - quo);
      end else begin
        t[m] = quo;
      end
    end
    return t;
  endfunction

  localparam tab_t SIG_TAB  = make_tab(1'b0);
  localparam tab_t TANH_TAB = make_tab(1'b1);

  // floor shift by 12, saturate to 16 bits
  function automatic logic signed [15:0] shift_sat(input logic signed [39:0] a);
    logic signed [27:0] s;
    s = a[39:12];
    if (s > 28'sd32767) begin
      return 16'sh7fff;
    end else if (s < -28'sd32768) begin
      return -16'sh8000;
    end
    return s[15:0];
  endfunction

endpackage

>>> hw/rtl/lcs_ram.sv
module lcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/lcs_cell.sv
module lcs_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  lcs_pkg::ring_ctl_t         ctl,
  input  lcs_pkg::cell_pos_t         pos,
  input  logic signed [15:0]         nb_h,
  input  logic signed [15:0]         nb_c,
  output logic signed [15:0]         hval,
  output logic signed [15:0]         cval
);

  always_ff @(posedge clk) begin
    if (rst) begin
      hval <= '0;
      cval <= '0;
    end else if (ctl.shift) begin
      // ring of hidden_len cells, the tail takes the wrap value
      if (pos.act) begin
        hval <= pos.tail ? ctl.wrap_h : nb_h;
        cval <= pos.tail ? ctl.wrap_c : nb_c;
      end
    end else begin
      if (ctl.wr_h && pos.sel) begin
        hval <= ctl.wdata;
      end
      if (ctl.wr_c && pos.sel) begin
        cval <= ctl.wdata;
      end
    end
  end

endmodule

>>> hw/rtl/lstm_cell_step.sv
// LSTM timestep engine (gates i, o, f, c; no peepholes; Q4.12). Load requests are taken only while
// the engine is idle. An input-element request with last set runs a timestep on one shared
// multiply-accumulate unit fed by the weight memories: it works through each of the 4*H gate rows,
// then each hidden unit produces its result, waiting while the output is stalled (H = hidden_len).
// Hidden and cell values live in a ring of cells that rotates once per gate row and once over the
// result phase. After reset a clearing pass zeroes all 8*HIDDEN_MAX bias memory entries; requests
// are held off until it ends.
module lstm_cell_step #(
  parameter int HIDDEN_MAX = 16,
  parameter int INPUT_MAX  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  lcs_pkg::req_t              req_data,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output lcs_pkg::rsp_t              rsp_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [lcs_pkg::CFG_W-1:0]  cfg_data
);

  localparam int HI = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
  localparam int HC = $clog2(HIDDEN_MAX + 1);
  localparam int XI = (INPUT_MAX > 1) ? $clog2(INPUT_MAX) : 1;
  localparam int XC = $clog2(INPUT_MAX + 1);
  localparam int QI = $clog2(4 * HIDDEN_MAX);
  localparam int BI = $clog2(8 * HIDDEN_MAX);
  localparam int WA = $clog2(4 * HIDDEN_MAX * INPUT_MAX);
  localparam int RA = $clog2(4 * HIDDEN_MAX * HIDDEN_MAX);
  localparam int KW = (XC > HC) ? XC : HC;
  localparam int DL_RST = (INPUT_MAX < 16) ? INPUT_MAX : 16;
  localparam int HL_RST = (HIDDEN_MAX < 16) ? HIDDEN_MAX : 16;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_BIAS_A = 14'b00000000000100,
    S_BIAS_B = 14'b00000000001000,
    S_BIAS_C = 14'b00000000010000,
    S_MAC_X  = 14'b00000000100000,
    S_MAC_H  = 14'b00000001000000,
    S_DRAIN  = 14'b00000010000000,
    S_GSTORE = 14'b00000100000000,
    S_OUT_RD = 14'b00001000000000,
    S_OUT_M1 = 14'b00010000000000,
    S_OUT_M2 = 14'b00100000000000,
    S_OUT_M3 = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } state_t;

  state_t             state;
  logic [XC-1:0]      dl;
  logic [HC-1:0]      hl;
  logic [QI-1:0]      q;
  logic [KW-1:0]      k;
  logic [HI-1:0]      u;
  logic [1:0]         j;
  logic               drain;
  logic [BI-1:0]      clr;
  logic [QI:0]        four_hl;
  logic               accept;
  logic               k_last_x;
  logic               k_last_h;
  logic               q_last;
  logic               u_last;
  logic               out_free;
  logic               fire;

  logic               s1_v;
  logic               s1_h;
  logic signed [15:0] s1_hval;
  logic               s2_v;
  logic signed [15:0] mac_w;
  logic signed [15:0] mac_x;
  logic signed [31:0] prod;
  logic signed [39:0] acc;
  logic signed [15:0] b1;
  logic signed [16:0] bsum;
  logic signed [15:0] gsat;
  logic signed [15:0] gi;
  logic signed [15:0] go;
  logic signed [15:0] gf;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [31:0] p3;
  logic signed [15:0] cn;
  logic signed [15:0] hn;

  logic [15:0]        w_rdata;
  logic [15:0]        r_rdata;
  logic [15:0]        x_rdata;
  logic [15:0]        b_rdata;
  logic [7:0]         g_rdata;
  logic               w_we;
  logic               r_we;
  logic               x_we;
  logic               b_we;
  logic [WA-1:0]      w_waddr;
  logic [WA-1:0]      w_raddr;
  logic [RA-1:0]      r_waddr;
  logic [RA-1:0]      r_raddr;
  logic [BI-1:0]      b_waddr;
  logic [BI-1:0]      b_raddr;
  logic [15:0]        b_wdata;
  logic [QI-1:0]      g_raddr;

  logic signed [15:0] h_cell [HIDDEN_MAX];
  logic signed [15:0] c_cell [HIDDEN_MAX];
  lcs_pkg::ring_ctl_t ring_ctl;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign four_hl   = (QI + 1)'(hl) << 2;
  assign k_last_x  = (k == KW'(dl) - 1'b1);
  assign k_last_h  = (k == KW'(hl) - 1'b1);
  assign q_last    = ({1'b0, q} == four_hl - 1'b1);
  assign u_last    = (u == HI'(hl - 1'b1));
  assign out_free  = !rsp_valid || !rsp_stall;
  assign fire      = (state == S_EMIT) && out_free;

  // load requests
  assign w_we = accept && (req_data.cmd == lcs_pkg::CMD_IN_WEIGHT) &&
                (32'(req_data.row) < 4 * HIDDEN_MAX) && (32'(req_data.col) < INPUT_MAX);
  assign r_we = accept && (req_data.cmd == lcs_pkg::CMD_REC_WEIGHT) &&
                (32'(req_data.row) < 4 * HIDDEN_MAX) && (32'(req_data.col) < HIDDEN_MAX);
  assign x_we = accept && (req_data.cmd == lcs_pkg::CMD_INPUT) &&
                (32'(req_data.col) < INPUT_MAX);
  assign b_we = (state == S_CLEAR) ||
                (accept && (req_data.cmd == lcs_pkg::CMD_BIAS) &&
                 (32'(req_data.row) < 8 * HIDDEN_MAX));

  assign w_waddr = WA'(req_data.row[QI-1:0]) * WA'(INPUT_MAX) + WA'(req_data.col[XI-1:0]);
  assign r_waddr = RA'(req_data.row[QI-1:0]) * RA'(HIDDEN_MAX) + RA'(req_data.col[HI-1:0]);
  assign w_raddr = WA'(q) * WA'(INPUT_MAX) + WA'(k[XI-1:0]);
  assign r_raddr = RA'(q) * RA'(HIDDEN_MAX) + RA'(k[HI-1:0]);
  assign b_waddr = (state == S_CLEAR) ? clr : req_data.row[BI-1:0];
  assign b_wdata = (state == S_CLEAR) ? '0 : req_data.value;
  // second bias half sits 4*hidden_len rows further up
  assign b_raddr = (state == S_BIAS_B) ? BI'(four_hl) + BI'(q) : BI'(q);
  assign g_raddr = QI'(j) * QI'(hl) + QI'(u);

  assign mac_w = s1_h ? $signed(r_rdata) : $signed(w_rdata);
  assign mac_x = s1_h ? s1_hval : $signed(x_rdata);
  assign bsum  = 17'(b1) + 17'($signed(b_rdata));
  assign gsat  = lcs_pkg::shift_sat(acc);
  assign hn    = lcs_pkg::shift_sat(40'(p3));

  lcs_ram #(.WIDTH(16), .DEPTH(4 * HIDDEN_MAX * INPUT_MAX)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(req_data.value),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  lcs_ram #(.WIDTH(16), .DEPTH(4 * HIDDEN_MAX * HIDDEN_MAX)) u_r_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(req_data.value),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  lcs_ram #(.WIDTH(16), .DEPTH(INPUT_MAX)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(req_data.col[XI-1:0]), .wdata(req_data.value),
    .raddr(k[XI-1:0]), .rdata(x_rdata)
  );

  lcs_ram #(.WIDTH(16), .DEPTH(8 * HIDDEN_MAX)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // gate values kept only as their table index
  lcs_ram #(.WIDTH(8), .DEPTH(4 * HIDDEN_MAX)) u_g_ram (
    .clk(clk), .we(state == S_GSTORE), .waddr(q), .wdata(gsat[15:8]),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  assign ring_ctl.shift  = (state == S_MAC_H) || fire;
  assign ring_ctl.wr_h   = accept && (req_data.cmd == lcs_pkg::CMD_H_INIT);
  assign ring_ctl.wr_c   = accept && (req_data.cmd == lcs_pkg::CMD_C_INIT);
  assign ring_ctl.wdata  = req_data.value;
  assign ring_ctl.wrap_h = (state == S_MAC_H) ? h_cell[0] : hn;
  assign ring_ctl.wrap_c = (state == S_MAC_H) ? c_cell[0] : cn;

  for (genvar i = 0; i < HIDDEN_MAX; i++) begin : g_cell
    localparam int NB = (i < HIDDEN_MAX - 1) ? i + 1 : 0;
    lcs_pkg::cell_pos_t pos;
    assign pos.sel  = (req_data.row == 9'(i));
    assign pos.tail = (HC'(i) == hl - 1'b1);
    assign pos.act  = (HC'(i) < hl);
    lcs_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ring_ctl), .pos(pos),
      .nb_h(h_cell[NB]), .nb_c(c_cell[NB]),
      .hval(h_cell[i]), .cval(c_cell[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      dl        <= XC'(DL_RST);
      hl        <= HC'(HL_RST);
      q         <= '0;
      k         <= '0;
      u         <= '0;
      j         <= '0;
      drain     <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lcs_pkg::REG_INPUT_LEN) begin
          if (cfg_data == '0) begin
            dl <= XC'(1);
          end else if (32'(cfg_data) > INPUT_MAX) begin
            dl <= XC'(INPUT_MAX);
          end else begin
            dl <= XC'(cfg_data);
          end
        end else begin
          if (cfg_data[6:0] == '0) begin
            hl <= HC'(1);
          end else if (32'(cfg_data[6:0]) > HIDDEN_MAX) begin
            hl <= HC'(HIDDEN_MAX);
          end else begin
            hl <= HC'(cfg_data[6:0]);
          end
        end
      end
      s1_v <= (state == S_MAC_X) || (state == S_MAC_H);
      s2_v <= s1_v;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == BI'(8 * HIDDEN_MAX - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (req_data.cmd == lcs_pkg::CMD_INPUT) && req_data.last) begin
            q     <= '0;
            state <= S_BIAS_A;
          end
        end
        S_BIAS_A: state <= S_BIAS_B;
        S_BIAS_B: state <= S_BIAS_C;
        S_BIAS_C: begin
          k     <= '0;
          state <= S_MAC_X;
        end
        S_MAC_X: begin
          if (k_last_x) begin
            k     <= '0;
            state <= S_MAC_H;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_MAC_H: begin
          if (k_last_h) begin
            drain <= 1'b0;
            state <= S_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DRAIN: begin
          // wait for the read and the product register to empty
          drain <= 1'b1;
          if (drain) begin
            state <= S_GSTORE;
          end
        end
        S_GSTORE: begin
          if (q_last) begin
            u     <= '0;
            j     <= '0;
            state <= S_OUT_RD;
          end else begin
            q     <= q + 1'b1;
            state <= S_BIAS_A;
          end
        end
        S_OUT_RD: begin
          j <= j + 1'b1;
          if (j == 2'd3) begin
            state <= S_OUT_M1;
          end
        end
        S_OUT_M1: state <= S_OUT_M2;
        S_OUT_M2: state <= S_OUT_M3;
        S_OUT_M3: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            if (u_last) begin
              state <= S_IDLE;
            end else begin
              u     <= u + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_BIAS_B) begin
      b1 <= $signed(b_rdata);
    end
    s1_h    <= (state == S_MAC_H);
    s1_hval <= h_cell[0];
    prod    <= mac_w * mac_x;
    if (state == S_BIAS_C) begin
      acc <= {{11{bsum[16]}}, bsum, 12'b0};
    end else if (s2_v) begin
      acc <= acc + 40'(prod);
    end
    if (state == S_OUT_RD) begin
      case (j)
        2'd1:    gi <= $signed(lcs_pkg::SIG_TAB[g_rdata]);
        2'd2:    go <= $signed(lcs_pkg::SIG_TAB[g_rdata]);
        2'd3:    gf <= $signed(lcs_pkg::SIG_TAB[g_rdata]);
        default: ;
      endcase
    end
    if (state == S_OUT_M1) begin
      p1 <= gf * c_cell[0];
      p2 <= gi * $signed(lcs_pkg::TANH_TAB[g_rdata]);
    end
    if (state == S_OUT_M2) begin
      cn <= lcs_pkg::shift_sat(40'(p1) + 40'(p2));
    end
    if (state == S_EMIT) begin
      p3 <= p3;
    end else begin
      p3 <= go * $signed(lcs_pkg::TANH_TAB[cn[15:8]]);
    end
    if (fire) begin
      rsp_data.unit        <= 6'(u);
      rsp_data.hidden_out  <= hn;
      rsp_data.cell_out    <= cn;
      rsp_data.end_of_step <= u_last;
    end
  end

`ifndef SYNTHESIS
  a_bias_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_BIAS_C) |-> !s2_v)
    else $error("product still in flight at bias load");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_GSTORE) |-> (!s1_v && !s2_v))
    else $error("gate stored before accumulation finished");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC_X) |-> (k < KW'(dl)))
    else $error("input index past input_len");

  a_fire_shows: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("result lost on ring shift");
`endif

endmodule
